// ===== design/cta_pkg.sv =====
// Shared constants, types and the sin^2 quarter-wave table of the cosine taper block.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package cta_pkg;

    localparam int MAX_LEN     = 4096;
    localparam int TABLE_BITS  = 10;
    localparam int POS_W       = $clog2(MAX_LEN);
    localparam int ZONE_W      = 12;
    localparam int CMP_W       = (POS_W > ZONE_W) ? POS_W : ZONE_W;
    localparam int Q_W         = 16;
    localparam int FRAC_BITS   = Q_W - TABLE_BITS;
    localparam int TAB_ENTRIES = (1 << TABLE_BITS) + 1;
    localparam int TAB_AW      = TABLE_BITS + 1;
    localparam int WGT_W       = 17;
    localparam int SMP_W       = 24;
    localparam int CFG_W       = 17;
    localparam int CFG_IDX_W   = 3;
    localparam int MODE_W      = 3;

    localparam logic [WGT_W-1:0] WEIGHT_ONE = WGT_W'(65536);

    // multiply-add unit operand widths
    localparam int MAC_A_W = 25;
    localparam int MAC_B_W = 18;
    localparam int MAC_W   = MAC_A_W + MAC_B_W;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MODE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_ONE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_END_ONE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_TWO = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_END_TWO   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RATIO     = 3'd5;

    // taper modes
    localparam logic [MODE_W-1:0] MODE_PASS   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_RISE   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_FALL   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_WINDOW = 3'd3;
    localparam logic [MODE_W-1:0] MODE_INVWIN = 3'd4;
    localparam logic [MODE_W-1:0] MODE_DAMP   = 3'd5;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef logic [WGT_W-1:0] t_sin2_tab [0:TAB_ENTRIES-1];

    typedef struct packed {
        logic                     start;
        logic [ZONE_W-1:0]        num;
        logic [ZONE_W-1:0]        den;
    } t_div_req;

    typedef struct packed {
        logic                     done;
        logic [Q_W-1:0]           quot;
    } t_div_stat;

    typedef struct packed {
        logic                     en;
        logic signed [MAC_A_W-1:0] a;
        logic signed [MAC_B_W-1:0] b;
        logic signed [MAC_W-1:0]   c;
    } t_mac_req;

    // sin^2 of a Q30 angle in Q16, Taylor series of sin then squared
    function automatic logic [WGT_W-1:0] sin2_of_angle(input logic [63:0] theta);
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] sq;
        term = theta;
        sum  = theta;
        for (int n = 1; n <= 8; n++) begin
            term = (term * theta) >> 30;
            term = (term * theta) >> 30;
            case (n)
                1: term = term / 64'd6;
                2: term = term / 64'd20;
                3: term = term / 64'd42;
                4: term = term / 64'd72;
                5: term = term / 64'd110;
                6: term = term / 64'd156;
                7: term = term / 64'd210;
                default: term = term / 64'd272;
            endcase
            if ((n % 2) == 1) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        sq = (sum * sum + (64'd1 << 43)) >> 44;
        if (sq > 64'd65536) begin
            sq = 64'd65536;
        end
        return sq[WGT_W-1:0];
    endfunction

    function automatic t_sin2_tab build_tab();
        t_sin2_tab tab;
        logic [63:0] theta;
        for (int k = 0; k < TAB_ENTRIES; k++) begin
            theta  = (HALF_PI_Q30 * 64'(k)) >> TABLE_BITS;
            tab[k] = sin2_of_angle(theta);
        end
        return tab;
    endfunction

    localparam t_sin2_tab SIN2_TAB = build_tab();

endpackage

`default_nettype wire

// ===== design/cosine_taper_window_apply.sv =====
// Cosine-squared taper window: scales each sample by a position-dependent Q1.16 weight.
// Transfer to registered result: pass and damping go straight to scaling; rise and
// fall first test zone one (inside it: divider pass, table reads, interpolation); the
// window modes do this for both zones and combine them. One item at a time: next
// transfer in the cycle after the result registers, later while the output is held.
// Synchronous active-low reset restores defaults, clears position, sets decay weight to one.
`timescale 1ns / 1ps
`default_nettype none

module cosine_taper_window_apply
    import cta_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [CFG_W-1:0]        i_cfg_data,
    input  wire logic                    i_valid,
    output logic                         o_ready,
    input  wire logic signed [SMP_W-1:0] i_sample_in,
    input  wire logic                    i_last_in,
    output logic                         o_valid,
    input  wire logic                    i_ready,
    output logic signed [SMP_W-1:0]      o_sample_out,
    output logic [WGT_W-1:0]             o_weight_out,
    output logic                         o_last_out
);

    typedef enum logic [3:0] {
        S_IDLE, S_ZONE, S_DIV, S_ROM0, S_ROM1, S_INTERP, S_RISE,
        S_COMBINE, S_WIN, S_SCALE, S_DECAY, S_DONE
    } t_state;

    localparam logic [FRAC_BITS:0] SPAN = (FRAC_BITS + 1)'(1 << FRAC_BITS);

    // configuration
    logic [MODE_W-1:0] r_mode;
    logic [ZONE_W-1:0] r_start_one, r_end_one, r_start_two, r_end_two;
    logic [CFG_W-1:0]  r_ratio;

    // trace state
    logic [POS_W-1:0]  r_pos;
    logic [WGT_W-1:0]  r_decay;

    // item in flight
    t_state                   r_state;
    logic signed [SMP_W-1:0]  r_sample;
    logic                     r_last;
    logic                     r_zone;
    logic [WGT_W-1:0]         r_rise;
    logic [WGT_W-1:0]         r_up;
    logic [WGT_W-1:0]         r_weight;
    logic signed [SMP_W-1:0]  r_res;

    // output register
    logic                     r_out_valid;
    logic signed [SMP_W-1:0]  r_out_sample;
    logic [WGT_W-1:0]         r_out_weight;
    logic                     r_out_last;

    t_div_req                 div_req;
    t_div_stat                div_stat;
    t_mac_req                 mac_req;
    logic signed [MAC_W-1:0]  mac_acc;
    logic [TAB_AW-1:0]        rom_addr;
    logic [WGT_W-1:0]         rom_data;

    logic [ZONE_W-1:0]        zs, ze;
    logic [CMP_W-1:0]         p_ext, s_ext, e_ext;
    logic [TABLE_BITS-1:0]    q_idx;
    logic [FRAC_BITS-1:0]     q_frac;
    logic [WGT_W-1:0]         ratio_c;
    logic [WGT_W-1:0]         win_w;
    logic                     out_free;

    cta_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_stat  (div_stat)
    );

    cta_mac u_mac (
        .i_clk (i_clk),
        .i_req (mac_req),
        .o_acc (mac_acc)
    );

    cta_rom u_rom (
        .i_clk  (i_clk),
        .i_addr (rom_addr),
        .o_data (rom_data)
    );

    always_comb begin
        zs       = r_zone ? r_start_two : r_start_one;
        ze       = r_zone ? r_end_two   : r_end_one;
        p_ext    = CMP_W'(r_pos);
        s_ext    = CMP_W'(zs);
        e_ext    = CMP_W'(ze);
        q_idx    = div_stat.quot[Q_W-1:FRAC_BITS];
        q_frac   = div_stat.quot[FRAC_BITS-1:0];
        ratio_c  = (r_ratio > CFG_W'(WEIGHT_ONE)) ? WEIGHT_ONE : r_ratio[WGT_W-1:0];
        win_w    = mac_acc[16 +: WGT_W];
        out_free = !r_out_valid || i_ready;

        div_req.start = (r_state == S_ZONE) && (p_ext >= s_ext) && (p_ext < e_ext);
        div_req.num   = ZONE_W'(p_ext - s_ext);
        div_req.den   = ze - zs;

        rom_addr = (r_state == S_ROM1) ? ({1'b0, q_idx} + TAB_AW'(1)) : {1'b0, q_idx};

        mac_req.en = 1'b0;
        mac_req.a  = '0;
        mac_req.b  = '0;
        mac_req.c  = '0;
        case (r_state)
            S_ROM1: begin
                // rom_data holds the lower table entry here
                mac_req.en = 1'b1;
                mac_req.a  = $signed(MAC_A_W'(rom_data));
                mac_req.b  = $signed(MAC_B_W'(SPAN - (FRAC_BITS + 1)'(q_frac)));
                mac_req.c  = $signed(MAC_W'(SPAN >> 1));
            end
            S_INTERP: begin
                mac_req.en = 1'b1;
                mac_req.a  = $signed(MAC_A_W'(rom_data));
                mac_req.b  = $signed(MAC_B_W'(q_frac));
                mac_req.c  = mac_acc;
            end
            S_COMBINE: begin
                mac_req.en = 1'b1;
                mac_req.a  = $signed(MAC_A_W'(r_up));
                mac_req.b  = $signed(MAC_B_W'(WEIGHT_ONE - r_rise));
                mac_req.c  = $signed(MAC_W'(32768));
            end
            S_SCALE: begin
                mac_req.en = 1'b1;
                mac_req.a  = MAC_A_W'(r_sample);
                mac_req.b  = $signed(MAC_B_W'(r_weight));
                mac_req.c  = $signed(MAC_W'(32768));
            end
            S_DECAY: begin
                mac_req.en = 1'b1;
                mac_req.a  = $signed(MAC_A_W'(r_decay));
                mac_req.b  = $signed(MAC_B_W'(ratio_c));
                mac_req.c  = $signed(MAC_W'(32768));
            end
            default: begin
                mac_req.en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= MODE_PASS;
            r_start_one <= '0;
            r_end_one   <= ZONE_W'(1);
            r_start_two <= '0;
            r_end_two   <= ZONE_W'(1);
            r_ratio     <= CFG_W'(WEIGHT_ONE);
            r_pos       <= '0;
            r_decay     <= WEIGHT_ONE;
            r_out_valid <= 1'b0;
            r_zone      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MODE:      r_mode      <= i_cfg_data[MODE_W-1:0];
                    CFG_START_ONE: r_start_one <= i_cfg_data[ZONE_W-1:0];
                    CFG_END_ONE:   r_end_one   <= i_cfg_data[ZONE_W-1:0];
                    CFG_START_TWO: r_start_two <= i_cfg_data[ZONE_W-1:0];
                    CFG_END_TWO:   r_end_two   <= i_cfg_data[ZONE_W-1:0];
                    CFG_RATIO:     r_ratio     <= i_cfg_data;
                    default: ;
                endcase
            end

            // drop the held result once transferred, unless a new one loads now
            if (r_out_valid && i_ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_sample <= i_sample_in;
                        r_last   <= i_last_in;
                        r_zone   <= 1'b0;
                        case (r_mode)
                            MODE_RISE, MODE_FALL, MODE_WINDOW, MODE_INVWIN: begin
                                r_state <= S_ZONE;
                            end
                            MODE_DAMP: begin
                                r_weight <= r_decay;
                                r_state  <= S_SCALE;
                            end
                            default: begin
                                r_weight <= WEIGHT_ONE;
                                r_state  <= S_SCALE;
                            end
                        endcase
                    end
                end
                S_ZONE: begin
                    // outside the zone the rise is flat; inside, start the quotient
                    if (p_ext < s_ext) begin
                        r_rise  <= '0;
                        r_state <= S_COMBINE;
                    end else if (p_ext >= e_ext) begin
                        r_rise  <= WEIGHT_ONE;
                        r_state <= S_COMBINE;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_stat.done) begin
                        r_state <= S_ROM0;
                    end
                end
                S_ROM0: begin
                    r_state <= S_ROM1;
                end
                S_ROM1: begin
                    r_state <= S_INTERP;
                end
                S_INTERP: begin
                    r_state <= S_RISE;
                end
                S_RISE: begin
                    r_rise  <= mac_acc[FRAC_BITS +: WGT_W];
                    r_state <= S_COMBINE;
                end
                S_COMBINE: begin
                    case (r_mode)
                        MODE_RISE: begin
                            r_weight <= r_rise;
                            r_state  <= S_SCALE;
                        end
                        MODE_FALL: begin
                            r_weight <= WEIGHT_ONE - r_rise;
                            r_state  <= S_SCALE;
                        end
                        default: begin
                            if (!r_zone) begin
                                r_up    <= r_rise;
                                r_zone  <= 1'b1;
                                r_state <= S_ZONE;
                            end else begin
                                r_state <= S_WIN;
                            end
                        end
                    endcase
                end
                S_WIN: begin
                    r_weight <= (r_mode == MODE_INVWIN) ? (WEIGHT_ONE - win_w) : win_w;
                    r_state  <= S_SCALE;
                end
                S_SCALE: begin
                    r_state <= S_DECAY;
                end
                S_DECAY: begin
                    r_res   <= mac_acc[16 +: SMP_W];
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    // hold until the output register can take the result
                    if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_sample <= r_res;
                        r_out_weight <= r_weight;
                        r_out_last   <= r_last;
                        if (r_last) begin
                            r_pos   <= '0;
                            r_decay <= WEIGHT_ONE;
                        end else begin
                            if (r_pos != POS_W'(MAX_LEN - 1)) begin
                                r_pos <= r_pos + POS_W'(1);
                            end
                            r_decay <= mac_acc[16 +: WGT_W];
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_ready      = (r_state == S_IDLE);
    assign o_valid      = r_out_valid;
    assign o_sample_out = r_out_sample;
    assign o_weight_out = r_out_weight;
    assign o_last_out   = r_out_last;

endmodule

`default_nettype wire

// ===== design/cta_div.sv =====
// Restoring divider, one quotient bit per cycle: quot = floor(num * 2^16 / den), num < den.
// Depends on cta_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cta_div
    import cta_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_div_req  i_req,
    output t_div_stat      o_stat
);

    localparam int CNT_W = $clog2(Q_W + 1);

    logic [ZONE_W-1:0] r_rem;
    logic [ZONE_W-1:0] r_den;
    logic [Q_W-1:0]    r_quot;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_done;

    logic [ZONE_W:0]   shifted;
    logic              fits;
    logic [ZONE_W:0]   diff;

    always_comb begin
        shifted = {r_rem, 1'b0};
        fits    = shifted >= {1'b0, r_den};
        diff    = shifted - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            // pulse after the last quotient bit
            r_done <= !i_req.start && (r_cnt == CNT_W'(1));
            if (i_req.start) begin
                r_rem <= i_req.num;
                r_den <= i_req.den;
                r_cnt <= CNT_W'(Q_W);
            end else if (r_cnt != '0) begin
                r_rem  <= fits ? diff[ZONE_W-1:0] : shifted[ZONE_W-1:0];
                r_quot <= {r_quot[Q_W-2:0], fits};
                r_cnt  <= r_cnt - CNT_W'(1);
            end
        end
    end

    assign o_stat.done = r_done;
    assign o_stat.quot = r_quot;

endmodule

`default_nettype wire

// ===== design/cta_mac.sv =====
// Shared signed multiply-add unit with a registered result: acc = a * b + c.
// Depends on cta_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cta_mac
    import cta_pkg::*;
(
    input  wire logic              i_clk,
    input  wire t_mac_req          i_req,
    output logic signed [MAC_W-1:0] o_acc
);

    logic signed [MAC_W-1:0] r_acc;

    // hold the result until the next operation is issued
    always_ff @(posedge i_clk) begin
        if (i_req.en) begin
            r_acc <= i_req.a * i_req.b + i_req.c;
        end
    end

    assign o_acc = r_acc;

endmodule

`default_nettype wire

// ===== design/cta_rom.sv =====
// sin^2 quarter-wave table ROM with a registered read port.
// Depends on cta_pkg for the table contents.
`timescale 1ns / 1ps
`default_nettype none

module cta_rom
    import cta_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic [TAB_AW-1:0] i_addr,
    output logic [WGT_W-1:0]       o_data
);

    logic [WGT_W-1:0] r_data;

    always_ff @(posedge i_clk) begin
        r_data <= SIN2_TAB[i_addr];
    end

    assign o_data = r_data;

endmodule

`default_nettype wire
